[rtl/core/sdpg_pkg.sv]
// Shared types, codes and constants for the step/direction pulse generator.
package sdpg_pkg;

    localparam int PERIOD_WIDTH_DEF   = 32;
    localparam int PRESCALE_WIDTH_DEF = 16;

    localparam int CLK_W   = 32;
    localparam int PRE_W   = 16;
    localparam int STEPS_W = 31;
    localparam int DIV_W   = 32;
    localparam int DSR_W   = 33;

    localparam logic [CLK_W-1:0] CLK_HZ_RST = 32'd16000000;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_DRIVE = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_ARGS  = 2'd1;
    localparam logic [1:0] STS_STOP_IDLE = 2'd2;

    localparam logic CFG_CLK_HZ    = 1'b0;
    localparam logic CFG_PRESCALER = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] step_count;
        logic [31:0]        step_rate;
    } in_item_t;

    typedef struct packed {
        logic       step_pulse;
        logic       dir_level;
        logic       enable_level;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic exec;
        logic capture;
        logic div_start;
        logic div_sel_rate;
        logic drive_load;
    } dp_cmd_t;

    typedef struct packed {
        logic drive_ok;
        logic div_done;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/core/sdpg_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module sdpg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sdpg_pkg::DIV_W-1:0]  dividend,
    input  logic [sdpg_pkg::DSR_W-1:0]  divisor,
    output logic                        done,
    output logic [sdpg_pkg::DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(sdpg_pkg::DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sdpg_pkg::DIV_W - 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [sdpg_pkg::DSR_W-1:0]  rem_reg;
    logic [sdpg_pkg::DIV_W-1:0]  quo_reg;
    logic [sdpg_pkg::DSR_W-1:0]  dsr_reg;

    logic [sdpg_pkg::DSR_W:0]    shifted;
    logic [sdpg_pkg::DSR_W+1:0]  diff;

    assign shifted = {rem_reg, quo_reg[sdpg_pkg::DIV_W-1]};
    // top bit of diff is the borrow
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[sdpg_pkg::DSR_W+1])
            begin
                rem_reg <= diff[sdpg_pkg::DSR_W-1:0];
                quo_reg <= {quo_reg[sdpg_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[sdpg_pkg::DSR_W-1:0];
                quo_reg <= {quo_reg[sdpg_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/sdpg_dp.sv]
// Datapath: configuration, motion state, timer counters, reload math, output register.
module sdpg_dp #(
    parameter int PERIOD_WIDTH   = sdpg_pkg::PERIOD_WIDTH_DEF,
    parameter int PRESCALE_WIDTH = sdpg_pkg::PRESCALE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_index,
    input  logic [sdpg_pkg::CLK_W-1:0]  cfg_data,
    input  sdpg_pkg::in_item_t          in_data,
    input  sdpg_pkg::dp_cmd_t           cmd,
    output sdpg_pkg::dp_sts_t           sts,
    output sdpg_pkg::out_item_t         out_data,
    output logic                        out_valid,
    input  logic                        out_ready
);

    logic [sdpg_pkg::CLK_W-1:0]    clk_hz_reg;
    logic [sdpg_pkg::PRE_W-1:0]    pre_reg;

    logic [sdpg_pkg::STEPS_W-1:0]  rem_reg, rem_next;
    logic                          dir_reg, dir_next;
    logic                          en_reg, en_next;
    logic [PERIOD_WIDTH-1:0]       reload_reg, reload_next;
    logic [PRESCALE_WIDTH-1:0]     pcnt_reg, pcnt_next;
    logic [PERIOD_WIDTH-1:0]       per_reg, per_next;

    logic [sdpg_pkg::STEPS_W-1:0]  mag_pend_reg;
    logic                          dir_pend_reg;
    logic [31:0]                   rate_pend_reg;

    logic                          out_valid_reg;
    sdpg_pkg::out_item_t           out_reg, out_next;

    // prescaler as seen at PRESCALE_WIDTH bits
    logic [PRESCALE_WIDTH+sdpg_pkg::PRE_W-1:0] pre_ext;
    logic [PRESCALE_WIDTH-1:0]                 pre_eff;
    logic [PRESCALE_WIDTH:0]                   pre_plus1;
    logic [PRESCALE_WIDTH+sdpg_pkg::DSR_W:0]   pre_div_ext;

    logic [sdpg_pkg::DIV_W-1:0]    div_dividend;
    logic [sdpg_pkg::DSR_W-1:0]    div_divisor;
    logic                          div_done;
    logic [sdpg_pkg::DIV_W-1:0]    div_quo;

    logic [31:0]                   cnt_u;
    logic [31:0]                   mag32;
    logic [sdpg_pkg::STEPS_W-1:0]  mag31;

    logic [31:0]                   quo_m1;
    logic [31:0]                   quo_hi;

    assign pre_ext     = {{PRESCALE_WIDTH{1'b0}}, pre_reg};
    assign pre_eff     = pre_ext[PRESCALE_WIDTH-1:0];
    assign pre_plus1   = {1'b0, pre_eff} + 1'b1;
    assign pre_div_ext = {{sdpg_pkg::DSR_W{1'b0}}, pre_plus1};

    // first pass: clock / (prescaler + 1); second pass: that / rate
    assign div_dividend = cmd.div_sel_rate ? div_quo : clk_hz_reg;
    assign div_divisor  = cmd.div_sel_rate ? {1'b0, rate_pend_reg}
                                           : pre_div_ext[sdpg_pkg::DSR_W-1:0];

    sdpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cnt_u = in_data.step_count;
    assign mag32 = cnt_u[31] ? (~cnt_u + 32'd1) : cnt_u;
    // most negative count saturates
    assign mag31 = mag32[31] ? '1 : mag32[sdpg_pkg::STEPS_W-1:0];

    assign quo_m1 = (div_quo == '0) ? '0 : (div_quo - 32'd1);
    assign quo_hi = quo_m1 >> PERIOD_WIDTH;

    assign sts.drive_ok = (in_data.action == sdpg_pkg::ACT_DRIVE)
                       && (in_data.step_count != '0) && (in_data.step_rate != '0);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        rem_next    = rem_reg;
        dir_next    = dir_reg;
        en_next     = en_reg;
        reload_next = reload_reg;
        pcnt_next   = pcnt_reg;
        per_next    = per_reg;
        out_next    = '0;

        if (cmd.exec)
        begin
            out_next.status = sdpg_pkg::STS_OK;
            case (in_data.action)
                sdpg_pkg::ACT_TICK:
                begin
                    if (en_reg)
                    begin
                        if (pcnt_reg >= pre_eff)
                        begin
                            pcnt_next = '0;
                            if (per_reg >= reload_reg)
                            begin
                                per_next = '0;
                                if (rem_reg == '0)
                                    en_next = 1'b0;
                                else
                                begin
                                    out_next.step_pulse = 1'b1;
                                    rem_next = rem_reg - 1'b1;
                                end
                            end
                            else
                                per_next = per_reg + 1'b1;
                        end
                        else
                            pcnt_next = pcnt_reg + 1'b1;
                    end
                end
                sdpg_pkg::ACT_DRIVE:
                    out_next.status = sdpg_pkg::STS_BAD_ARGS;
                sdpg_pkg::ACT_STOP:
                begin
                    if (!en_reg)
                        out_next.status = sdpg_pkg::STS_STOP_IDLE;
                    else
                    begin
                        rem_next = '0;
                        en_next  = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.drive_load)
        begin
            rem_next    = mag_pend_reg;
            dir_next    = dir_pend_reg;
            en_next     = 1'b1;
            pcnt_next   = '0;
            per_next    = '0;
            reload_next = (quo_hi != '0) ? '1 : quo_m1[PERIOD_WIDTH-1:0];
            out_next.status = sdpg_pkg::STS_OK;
        end

        out_next.dir_level    = dir_next;
        out_next.enable_level = en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg    <= sdpg_pkg::CLK_HZ_RST;
            pre_reg       <= '0;
            rem_reg       <= '0;
            dir_reg       <= 1'b1;
            en_reg        <= 1'b0;
            reload_reg    <= '0;
            pcnt_reg      <= '0;
            per_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    sdpg_pkg::CFG_CLK_HZ:    clk_hz_reg <= cfg_data;
                    sdpg_pkg::CFG_PRESCALER: pre_reg    <= cfg_data[sdpg_pkg::PRE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            rem_reg    <= rem_next;
            dir_reg    <= dir_next;
            en_reg     <= en_next;
            reload_reg <= reload_next;
            pcnt_reg   <= pcnt_next;
            per_reg    <= per_next;
            if (cmd.exec || cmd.drive_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_pend_reg  <= mag31;
            dir_pend_reg  <= !cnt_u[31];
            rate_pend_reg <= in_data.step_rate;
        end
        if (cmd.exec || cmd.drive_load)
            out_reg <= out_next;
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

[rtl/core/sdpg_ctrl.sv]
// Controller: accepts items and sequences the two reload divisions of a drive command.
module sdpg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdpg_pkg::dp_sts_t   sts,
    output sdpg_pkg::dp_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_CLK,
        ST_DIV_RATE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (sts.drive_ok)
                    begin
                        cmd.capture   = 1'b1;
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV_CLK;
                    end
                    else
                        cmd.exec = 1'b1;
                end
            end
            ST_DIV_CLK:
            begin
                if (sts.div_done)
                begin
                    cmd.div_start    = 1'b1;
                    cmd.div_sel_rate = 1'b1;
                    state_next       = ST_DIV_RATE;
                end
            end
            ST_DIV_RATE:
            begin
                if (sts.div_done)
                begin
                    cmd.drive_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/step_dir_pulse_generator_core.sv]
// Top level of the step/direction pulse generator.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------
//   in      | in_valid / in_ready    | in_data  (action, step_count, step_rate)
//   out     | out_valid / out_ready  | out_data (step_pulse, dir_level, enable_level, status)
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Tick, stop, rejected drive and unused actions are executed when accepted; one
// transaction per cycle while the output is drained.
// An accepted drive has its result once the shared radix-2 divider has run twice
// (clock / (prescaler + 1), then / rate); the input is held off meanwhile.
// Reset loads control, config and motion registers with initial values; no clearing pass.
// The input stalls while a result waits on a stalled output.
module step_dir_pulse_generator_core #(
    parameter int PERIOD_WIDTH   = sdpg_pkg::PERIOD_WIDTH_DEF,
    parameter int PRESCALE_WIDTH = sdpg_pkg::PRESCALE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sdpg_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sdpg_pkg::out_item_t         out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [sdpg_pkg::CLK_W-1:0]  cfg_data
);

    sdpg_pkg::dp_cmd_t cmd;
    sdpg_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    sdpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdpg_dp #(
        .PERIOD_WIDTH   (PERIOD_WIDTH),
        .PRESCALE_WIDTH (PRESCALE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

[rtl/core/sdpg_checker.sv]
// Port-level checks for the step/direction pulse generator, bound to the top level.
module sdpg_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input sdpg_pkg::out_item_t  out_data
);

    // a pulse is only issued while the driver stays enabled
    a_pulse_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.step_pulse |-> out_data.enable_level)
        else $error("step pulse with driver disabled");

    a_pulse_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.step_pulse |-> out_data.status == sdpg_pkg::STS_OK)
        else $error("step pulse with error status");

    // no new transaction while a result is stuck on the output
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

endmodule

bind step_dir_pulse_generator_core sdpg_checker u_sdpg_checker (.*);
